// ----- hdl/wspcm_pkg.sv -----
`timescale 1ns / 1ps

package wspcm_pkg;

  typedef enum logic [2:0] {
    FMT_PCM8  = 3'd0,
    FMT_PCM16 = 3'd1,
    FMT_PCM24 = 3'd2,
    FMT_PCM32 = 3'd3,
    FMT_F32   = 3'd4,
    FMT_F64   = 3'd5
  } sample_fmt_e;

  localparam logic [2:0] FMT_RESET = FMT_PCM16;

  // gathered sample handed from the assembler to the converter
  typedef struct packed {
    logic [63:0] raw;
    logic [2:0]  fmt;
  } wspcm_sample_t;

  // byte count of one sample; zero marks an unused code
  function automatic logic [3:0] bytes_for_format(logic [2:0] fmt);
    logic [3:0] n;
    case (fmt)
      FMT_PCM8:  n = 4'd1;
      FMT_PCM16: n = 4'd2;
      FMT_PCM24: n = 4'd3;
      FMT_PCM32: n = 4'd4;
      FMT_F32:   n = 4'd4;
      FMT_F64:   n = 4'd8;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/wspcm_ifs.sv -----
`timescale 1ns / 1ps

interface wspcm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface wspcm_pcm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  modport source (output valid, output pcm_sample, input ready);
  modport sink (input valid, input pcm_sample, output ready);
endinterface

interface wspcm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] sample_format;
  modport source (output valid, output sample_format, input ready);
  modport sink (input valid, input sample_format, output ready);
endinterface

// ----- hdl/wav_sample_to_pcm16_unit.sv -----
`timescale 1ns / 1ps

// Converts a little-endian byte stream into signed 16-bit PCM samples. The
// format register selects 8-bit offset binary, 16, 24 or 32-bit signed, or
// IEEE float32/float64; integer formats are scaled by truncation toward zero,
// floats are multiplied by 32768, saturated and truncated, and NaN gives 0.
// One byte is taken per clock while the output does not stall; a sample
// leaves once its format's 1 to 8 bytes are in, and passes from its last
// byte through the gather register and then the output register.
// Writing the format discards a partly gathered sample; unused codes drop
// every byte without a result.

module wav_sample_to_pcm16_unit
  import wspcm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wspcm_byte_if.sink  byte_i,
  wspcm_cfg_if.sink   cfg_i,
  wspcm_pcm_if.source pcm_o
);

  wspcm_sample_t sample;
  logic          sample_valid;
  logic          sample_ready;

  wspcm_assemble u_assemble (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_i         (byte_i),
    .cfg_i          (cfg_i),
    .sample_o       (sample),
    .sample_valid_o (sample_valid),
    .sample_ready_i (sample_ready)
  );

  wspcm_convert u_convert (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample),
    .sample_valid_i (sample_valid),
    .sample_ready_o (sample_ready),
    .pcm_o          (pcm_o)
  );

endmodule

// ----- hdl/wspcm_assemble.sv -----
`timescale 1ns / 1ps

module wspcm_assemble
  import wspcm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  wspcm_byte_if.sink          byte_i,
  wspcm_cfg_if.sink           cfg_i,
  output wspcm_sample_t       sample_o,
  output logic                sample_valid_o,
  input  logic                sample_ready_i
);

  logic [2:0]    fmt_q;
  logic [55:0]   asm_q, asm_d;
  logic [2:0]    held_q, held_d;
  logic          s_valid_q, s_valid_d;
  wspcm_sample_t s_q, s_d;

  logic          advance;
  logic          byte_fire;
  logic          cfg_fire;
  logic [3:0]    need;
  logic [63:0]   raw;
  logic          complete;

  assign advance      = !s_valid_q || sample_ready_i;
  assign byte_i.ready = advance;
  assign byte_fire    = byte_i.valid && advance;
  assign cfg_i.ready  = 1'b1;
  assign cfg_fire     = cfg_i.valid;
  assign need         = bytes_for_format(fmt_q);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (held_q == i[2:0]) begin
        raw[i*8 +: 8] = byte_i.data_byte;
      end else if (i < 7) begin
        raw[i*8 +: 8] = asm_q[i*8 +: 8];
      end else begin
        raw[i*8 +: 8] = 8'h00;
      end
    end
  end

  assign complete = ({1'b0, held_q} + 4'd1) >= need;

  always_comb begin
    asm_d     = asm_q;
    held_d    = held_q;
    s_valid_d = s_valid_q && !sample_ready_i;
    s_d       = s_q;
    if (cfg_fire) begin
      held_d = 3'd0;
    end else if (byte_fire) begin
      if (need == 4'd0) begin
        held_d = 3'd0;
      end else if (!complete) begin
        asm_d  = raw[55:0];
        held_d = held_q + 3'd1;
      end else begin
        held_d    = 3'd0;
        s_valid_d = 1'b1;
        s_d.raw   = raw;
        s_d.fmt   = fmt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_RESET;
      held_q    <= 3'd0;
      s_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        fmt_q <= cfg_i.sample_format;
      end
      held_q    <= held_d;
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
    s_q   <= s_d;
  end

  assign sample_o       = s_q;
  assign sample_valid_o = s_valid_q;

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> held_q == 3'd0)
    else $error("partial sample survived a format write");

  a_held_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != 3'd0 |-> {1'b0, held_q} < need)
    else $error("byte count reached sample size without completing");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q && !sample_ready_i |=> s_valid_q && $stable(s_q))
    else $error("gathered sample changed while stalled");

endmodule

// ----- hdl/wspcm_convert.sv -----
`timescale 1ns / 1ps

module wspcm_convert
  import wspcm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wspcm_sample_t sample_i,
  input  logic          sample_valid_i,
  output logic          sample_ready_o,
  wspcm_pcm_if.source   pcm_o
);

  // significand is aligned to 53 bits, so float32 takes 29 more shift
  localparam logic [10:0] LIMIT_F32 = 11'd164;
  localparam logic [10:0] LIMIT_F64 = 11'd1060;
  localparam logic [16:0] MAG_SAT   = 17'h10000;

  logic        out_valid_q;
  logic [15:0] pcm_q, pcm_d;
  logic        in_fire;

  logic        f_neg;
  logic [10:0] f_exp;
  logic [10:0] f_eeff;
  logic [51:0] f_man;
  logic [52:0] f_sig;
  logic [10:0] f_limit;
  logic        f_emax;
  logic [10:0] f_shift;
  logic [52:0] f_shifted;
  logic [24:0] mag24;
  logic [32:0] mag32;
  logic        neg;
  logic [16:0] mag;
  logic        packed_out;

  assign sample_ready_o = !out_valid_q || pcm_o.ready;
  assign in_fire        = sample_valid_i && sample_ready_o;

  always_comb begin
    if (sample_i.fmt == FMT_F32) begin
      f_neg   = sample_i.raw[31];
      f_exp   = {3'd0, sample_i.raw[30:23]};
      f_man   = {sample_i.raw[22:0], 29'd0};
      f_emax  = sample_i.raw[30:23] == 8'hFF;
      f_limit = LIMIT_F32;
    end else begin
      f_neg   = sample_i.raw[63];
      f_exp   = sample_i.raw[62:52];
      f_man   = sample_i.raw[51:0];
      f_emax  = sample_i.raw[62:52] == 11'h7FF;
      f_limit = LIMIT_F64;
    end
    f_sig     = {f_exp != 11'd0, f_man};
    f_eeff    = (f_exp == 11'd0) ? 11'd1 : f_exp;
    f_shift   = f_limit - f_eeff;
    f_shifted = f_sig >> f_shift[5:0];
  end

  assign mag24 = sample_i.raw[23] ? (25'h1000000 - {1'b0, sample_i.raw[23:0]})
                                  : {1'b0, sample_i.raw[23:0]};
  assign mag32 = sample_i.raw[31] ? (33'h100000000 - {1'b0, sample_i.raw[31:0]})
                                  : {1'b0, sample_i.raw[31:0]};

  always_comb begin
    neg        = 1'b0;
    mag        = 17'd0;
    packed_out = 1'b1;
    pcm_d      = 16'h0000;
    case (sample_i.fmt)
      FMT_PCM8: begin
        packed_out = 1'b0;
        pcm_d      = {~sample_i.raw[7], sample_i.raw[6:0], 8'h00};
      end
      FMT_PCM16: begin
        packed_out = 1'b0;
        pcm_d      = sample_i.raw[15:0];
      end
      FMT_PCM24: begin
        neg = sample_i.raw[23];
        mag = mag24[24:8];
      end
      FMT_PCM32: begin
        neg = sample_i.raw[31];
        mag = mag32[32:16];
      end
      FMT_F32, FMT_F64: begin
        neg = f_neg;
        if (f_emax) begin
          if (f_man != 52'd0) begin
            neg = 1'b0;
            mag = 17'd0;
          end else begin
            mag = MAG_SAT;
          end
        end else if (f_eeff >= f_limit) begin
          mag = MAG_SAT;
        end else if (f_shift >= 11'd53) begin
          mag = 17'd0;
        end else if (|f_shifted[52:17]) begin
          mag = MAG_SAT;
        end else begin
          mag = f_shifted[16:0];
        end
      end
      default: begin
        packed_out = 1'b0;
      end
    endcase
    if (packed_out) begin
      if (neg) begin
        pcm_d = (mag > 17'd32768) ? 16'h8000 : (16'd0 - mag[15:0]);
      end else begin
        pcm_d = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sample_ready_o) begin
      out_valid_q <= sample_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pcm_q <= pcm_d;
    end
  end

  assign pcm_o.valid      = out_valid_q;
  assign pcm_o.pcm_sample = pcm_q;

  a_nan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (sample_i.fmt == FMT_F32 || sample_i.fmt == FMT_F64) && f_emax
      && f_man != 52'd0 |=> pcm_q == 16'h0000)
    else $error("NaN did not convert to zero");

endmodule
